@@ rtl/core/vgd_pkg.sv @@
// Shared constants, types and state encoding for the voxel grid downsampler.
package vgd_pkg;

  localparam int unsigned SLOTS     = 64;
  localparam int unsigned SLOT_CW   = 7;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned INT_W     = 16;
  localparam int unsigned CNT_W     = 14;
  localparam int unsigned SUM_W     = COORD_W + CNT_W;
  localparam int unsigned ISUM_W    = INT_W + CNT_W;
  localparam int unsigned VSIZE_W   = 31;
  localparam int unsigned DVD_W     = SUM_W;
  localparam int unsigned STEP_W    = 6;
  localparam int unsigned DATA_W    = 120;

  localparam logic [CNT_W-1:0] COUNT_MAX = 14'd16383;

  localparam logic       FUNC_ADD       = 1'b0;
  localparam logic [0:0] REG_VOXEL_SIZE = 1'b0;
  localparam logic [0:0] REG_USE_AVG    = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OVF     = 2'd1;
  localparam logic [1:0] ST_BADSIZE = 2'd2;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] xyz;
    logic [INT_W-1:0]        inten;
    logic                    has;
  } point_t;

  typedef struct packed {
    logic [2:0][KEY_W-1:0] key;
    logic [2:0][SUM_W-1:0] sum;
    logic [ISUM_W-1:0]     isum;
    logic [CNT_W-1:0]      cnt;
    logic [CNT_W-1:0]      icnt;
    point_t                first;
  } slot_t;

  typedef struct packed {
    logic upd;
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_KGO,
    S_KWAIT,
    S_UPD,
    S_EHEAD,
    S_EGO,
    S_EWAIT,
    S_OUT,
    S_ERR
  } state_e;

endpackage

@@ rtl/core/vgd_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
module vgd_div import vgd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DVD_W-1:0]   dvd_i,
  input  logic [VSIZE_W-1:0] dsr_i,
  input  logic [STEP_W-1:0]  steps_i,
  output logic               done_o,
  output logic [DVD_W-1:0]   quo_o,
  output logic               rem_nz_o
);

  logic               busy_q;
  logic               done_q;
  logic [STEP_W-1:0]  cnt_q;
  logic [DVD_W-1:0]   dvd_q;
  logic [VSIZE_W-1:0] rem_q;
  logic [VSIZE_W-1:0] dsr_q;
  logic [DVD_W-1:0]   quo_q;
  logic [VSIZE_W:0]   trial;
  logic               ge;
  logic [VSIZE_W:0]   diff;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_i;
      dsr_q <= dsr_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      rem_q <= ge ? diff[VSIZE_W-1:0] : trial[VSIZE_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o   = done_q;
  assign quo_o    = quo_q;
  assign rem_nz_o = |rem_q;

endmodule

@@ rtl/core/vgd_cell.sv @@
// One voxel slot: key match, accumulation, allocation and shift toward the head.
module vgd_cell import vgd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic                  alloc_i,
  input  logic [2:0][KEY_W-1:0] key_i,
  input  point_t                pt_i,
  input  logic                  nxt_valid_i,
  input  slot_t                 nxt_slot_i,
  output logic                  valid_o,
  output slot_t                 slot_o,
  output logic                  hit_o
);

  logic  valid_q;
  slot_t slot_q;

  assign hit_o   = valid_q && (slot_q.key == key_i);
  assign valid_o = valid_q;
  assign slot_o  = slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= nxt_valid_i;
    end else if (alloc_i) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      slot_q <= nxt_slot_i;
    end else if (alloc_i) begin
      slot_q.key   <= key_i;
      for (int a = 0; a < 3; a++) begin
        slot_q.sum[a] <= {{(SUM_W-COORD_W){pt_i.xyz[a][COORD_W-1]}}, pt_i.xyz[a]};
      end
      slot_q.cnt   <= CNT_W'(1);
      slot_q.isum  <= pt_i.has ? ISUM_W'(pt_i.inten) : '0;
      slot_q.icnt  <= pt_i.has ? CNT_W'(1) : '0;
      slot_q.first <= pt_i.has ? pt_i : point_t'{xyz: pt_i.xyz, inten: '0, has: 1'b0};
    end else if (ctrl_i.upd && hit_o && (slot_q.cnt < COUNT_MAX)) begin
      for (int a = 0; a < 3; a++) begin
        slot_q.sum[a] <= slot_q.sum[a] +
                         {{(SUM_W-COORD_W){pt_i.xyz[a][COORD_W-1]}}, pt_i.xyz[a]};
      end
      slot_q.cnt <= slot_q.cnt + 1'b1;
      if (pt_i.has && (slot_q.icnt < COUNT_MAX)) begin
        slot_q.isum <= slot_q.isum + ISUM_W'(pt_i.inten);
        slot_q.icnt <= slot_q.icnt + 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/voxel_grid_downsample_unit.sv @@
// Voxel grid downsampler top level: control, key and average division, slot chain.
// Points are taken one at a time. Each accepted point passes through three
// 32-step serial divisions by the voxel size in the shared divider, one quotient
// bit per cycle, then a lookup/update across the slot chain, before the input
// is ready again. An add point marked last starts an emission run of one result
// per occupied voxel in order of first appearance; in averaging mode each result
// takes three 46-step and one 30-step divisions, in first-point mode none, plus
// any wait on m_axis_tready. Results leave from the head of the chain, which
// then shifts by one slot. A zero voxel size yields one result with status 2 on
// the last point. No input is taken during an emission run.
module voxel_grid_downsample_unit import vgd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // point_x, point_y, point_z, point_intensity, intensity_present, zero pad
  input  logic [DATA_W-1:0]  s_axis_tdata,
  input  logic               s_axis_tlast,
  // func
  input  logic [0:0]         s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // out_x, out_y, out_z, out_intensity, out_has_intensity, zero pad
  output logic [DATA_W-1:0]  m_axis_tdata,
  output logic               m_axis_tlast,
  // status
  output logic [1:0]         m_axis_tuser,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [VSIZE_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [VSIZE_W-1:0]    vsize_q;
  logic                  avg_q;
  point_t                pt_q;
  logic                  last_q;
  logic [1:0]            axis_q;
  logic [2:0][KEY_W-1:0] key_q;
  logic [SLOT_CW-1:0]    used_q;
  logic                  ovf_q;
  logic [SLOT_CW-1:0]    emit_q;
  logic [2:0][COORD_W-1:0] oxyz_q;
  logic [INT_W-1:0]      oi_q;
  logic                  oh_q;
  logic [1:0]            ost_q;
  logic                  olast_q;

  cell_ctrl_t            ctrl;
  logic                  in_acc;
  logic                  div_start;
  logic [DVD_W-1:0]      div_dvd;
  logic [VSIZE_W-1:0]    div_dsr;
  logic [STEP_W-1:0]     div_steps;
  logic                  div_done;
  logic [DVD_W-1:0]      div_quo;
  logic                  div_rem_nz;
  logic [COORD_W-1:0]    cabs;
  logic [SUM_W-1:0]      sabs;
  logic [KEY_W-1:0]      key_res;
  logic [COORD_W-1:0]    sum_res;
  logic                  any_hit;
  logic                  head_final;

  logic [SLOTS:0]        cell_valid;
  slot_t                 cell_slot [SLOTS+1];
  logic [SLOTS-1:0]      hit;
  logic [SLOTS-1:0]      alloc;
  slot_t                 head;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign head       = cell_slot[0];
  assign any_hit    = |hit;
  assign head_final = (emit_q + 1'b1) == used_q;

  assign cell_valid[SLOTS] = 1'b0;
  assign cell_slot[SLOTS]  = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign alloc[i] = ctrl.upd && !any_hit && (used_q == SLOT_CW'(i));
    vgd_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .alloc_i     (alloc[i]),
      .key_i       (key_q),
      .pt_i        (pt_q),
      .nxt_valid_i (cell_valid[i+1]),
      .nxt_slot_i  (cell_slot[i+1]),
      .valid_o     (cell_valid[i]),
      .slot_o      (cell_slot[i]),
      .hit_o       (hit[i])
    );
  end

  vgd_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .dvd_i    (div_dvd),
    .dsr_i    (div_dsr),
    .steps_i  (div_steps),
    .done_o   (div_done),
    .quo_o    (div_quo),
    .rem_nz_o (div_rem_nz)
  );

  // operand select for the shared divider and signed key and average results
  always_comb begin
    cabs = pt_q.xyz[axis_q][COORD_W-1] ? (~pt_q.xyz[axis_q] + 1'b1) : pt_q.xyz[axis_q];
    sabs = head.sum[axis_q][SUM_W-1] ? (~head.sum[axis_q] + 1'b1) : head.sum[axis_q];
    if (state_q == S_KGO) begin
      div_dvd   = {cabs, (DVD_W-COORD_W)'(0)};
      div_dsr   = vsize_q;
      div_steps = STEP_W'(COORD_W);
    end else if (axis_q == 2'd3) begin
      div_dvd   = {head.isum, (DVD_W-ISUM_W)'(0)};
      div_dsr   = VSIZE_W'(head.icnt);
      div_steps = STEP_W'(ISUM_W);
    end else begin
      div_dvd   = sabs;
      div_dsr   = VSIZE_W'(head.cnt);
      div_steps = STEP_W'(SUM_W);
    end
    key_res = pt_q.xyz[axis_q][COORD_W-1] ?
              (div_rem_nz ? ~div_quo[KEY_W-1:0] : (~div_quo[KEY_W-1:0] + 1'b1)) :
              div_quo[KEY_W-1:0];
    sum_res = head.sum[axis_q][SUM_W-1] ? (~div_quo[COORD_W-1:0] + 1'b1) :
              div_quo[COORD_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && (s_axis_tuser[0] == FUNC_ADD)) begin
          if (vsize_q == '0) begin
            state_d = s_axis_tlast ? S_ERR : S_IDLE;
          end else begin
            state_d = S_KGO;
          end
        end
      end
      S_KGO:   state_d = S_KWAIT;
      S_KWAIT: begin
        if (div_done) begin
          state_d = (axis_q == 2'd2) ? S_UPD : S_KGO;
        end
      end
      S_UPD:   state_d = last_q ? S_EHEAD : S_IDLE;
      S_EHEAD: begin
        if (used_q == '0) begin
          state_d = S_IDLE;
        end else begin
          state_d = avg_q ? S_EGO : S_OUT;
        end
      end
      S_EGO:   state_d = S_EWAIT;
      S_EWAIT: begin
        if (div_done) begin
          state_d = (axis_q == 2'd3) ? S_OUT : S_EGO;
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          state_d = head_final ? S_IDLE : S_EHEAD;
        end
      end
      S_ERR: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    m_axis_tvalid = (state_q == S_OUT) || (state_q == S_ERR);
    div_start     = (state_q == S_KGO) || (state_q == S_EGO);
    ctrl.upd      = (state_q == S_UPD);
    ctrl.shift    = (state_q == S_OUT) && m_axis_tready;
    ctrl.clear    = ((state_q == S_ERR) && m_axis_tready) ||
                    ((state_q == S_EHEAD) && (used_q == '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vsize_q <= VSIZE_W'(65536);
      avg_q   <= 1'b1;
      axis_q  <= '0;
      used_q  <= '0;
      ovf_q   <= 1'b0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && (cfg_idx_i == REG_VOXEL_SIZE)) begin
        vsize_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == REG_USE_AVG)) begin
        avg_q <= cfg_data_i[0];
      end
      case (state_q)
        S_IDLE:  axis_q <= '0;
        S_KWAIT: begin
          if (div_done) begin
            axis_q <= axis_q + 1'b1;
          end
        end
        S_UPD: begin
          emit_q <= '0;
          if (!any_hit) begin
            if (used_q == SLOT_CW'(SLOTS)) begin
              ovf_q <= 1'b1;
            end else begin
              used_q <= used_q + 1'b1;
            end
          end
        end
        S_EHEAD: begin
          axis_q <= '0;
          if (used_q == '0) begin
            ovf_q <= 1'b0;
          end
        end
        S_EWAIT: begin
          if (div_done) begin
            axis_q <= axis_q + 1'b1;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            emit_q <= emit_q + 1'b1;
            if (head_final) begin
              used_q <= '0;
              ovf_q  <= 1'b0;
            end
          end
        end
        S_ERR: begin
          if (m_axis_tready) begin
            used_q <= '0;
            ovf_q  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        pt_q.xyz[0] <= s_axis_tdata[31:0];
        pt_q.xyz[1] <= s_axis_tdata[63:32];
        pt_q.xyz[2] <= s_axis_tdata[95:64];
        pt_q.inten  <= s_axis_tdata[111:96];
        pt_q.has    <= s_axis_tdata[112];
        last_q      <= s_axis_tlast;
        if (in_acc) begin
          oxyz_q  <= '0;
          oi_q    <= '0;
          oh_q    <= 1'b0;
          ost_q   <= ST_BADSIZE;
          olast_q <= 1'b1;
        end
      end
      S_KWAIT: begin
        if (div_done) begin
          key_q[axis_q] <= key_res;
        end
      end
      S_EHEAD: begin
        oxyz_q  <= head.first.xyz;
        oi_q    <= head.first.inten;
        oh_q    <= head.first.has;
        ost_q   <= ovf_q ? ST_OVF : ST_OK;
        olast_q <= head_final;
      end
      S_EWAIT: begin
        if (div_done) begin
          if (axis_q == 2'd3) begin
            oi_q <= (head.icnt != '0) ? div_quo[INT_W-1:0] : '0;
            oh_q <= (head.icnt != '0);
          end else begin
            oxyz_q[axis_q] <= sum_res;
          end
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {7'd0, oh_q, oi_q, oxyz_q[2], oxyz_q[1], oxyz_q[0]};
  assign m_axis_tlast = olast_q;
  assign m_axis_tuser = ost_q;

`ifndef SYNTHESIS
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= SLOT_CW'(SLOTS))
    else $error("slot count beyond table size");
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result is pending");
  a_alloc_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(alloc) && !(any_hit && (|alloc)))
    else $error("slot allocated more than once or on a hit");
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_BADSIZE)) |-> cell_valid[0])
    else $error("result emitted from an empty slot");
  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.upd |-> $onehot0(hit))
    else $error("voxel key present in more than one slot");
`endif

endmodule

@@ dv/tb_voxel_grid_downsample_unit.sv @@
// Testbench for the voxel grid downsampler: self-predicting scoreboard, directed and random stream traffic.
`timescale 1ns / 1ps
module tb_voxel_grid_downsample_unit;
  import vgd_pkg::*;

  typedef struct {
    logic [31:0] x, y, z;
    logic [15:0] inten;
    logic        has;
    logic [1:0]  st;
    logic        last;
  } vox_out_t;

  class voxel_scoreboard;
    longint      key[SLOTS][3];
    longint      sum[SLOTS][3];
    longint      first[SLOTS][3];
    int unsigned isum[SLOTS], cnt[SLOTS], icnt[SLOTS], first_int[SLOTS];
    bit          first_has[SLOTS];
    int unsigned used;
    bit          ovf;
    int unsigned vsize = 65536;
    bit          avg = 1;
    vox_out_t    pending[$];
    int          errors;
    int          seen;

    function longint floor_div(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q -= 1;
      return q;
    endfunction

    function void push(longint x, longint y, longint z, int unsigned i, bit h,
                       logic [1:0] st, bit l);
      vox_out_t o;
      o.x = x[31:0]; o.y = y[31:0]; o.z = z[31:0];
      o.inten = i[15:0]; o.has = h; o.st = st; o.last = l;
      pending = {pending, o};
    endfunction

    function void note_point(logic f, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz, logic [15:0] pi, logic ph, logic pl);
      longint p[3], k[3], c;
      int     hit;
      if (f != FUNC_ADD) return;
      if (vsize == 0) begin
        if (pl) begin
          push(0, 0, 0, 0, 0, ST_BADSIZE, 1);
          used = 0; ovf = 0;
        end
        return;
      end
      p[0] = longint'(signed'(px)); p[1] = longint'(signed'(py));
      p[2] = longint'(signed'(pz));
      for (int a = 0; a < 3; a++) k[a] = floor_div(p[a], vsize);
      hit = -1;
      for (int s = 0; s < used; s++)
        if (hit < 0 && key[s][0] == k[0] && key[s][1] == k[1] && key[s][2] == k[2]) hit = s;
      if (hit >= 0) begin
        if (cnt[hit] < COUNT_MAX) begin
          for (int a = 0; a < 3; a++) sum[hit][a] += p[a];
          cnt[hit]++;
          if (ph && icnt[hit] < COUNT_MAX) begin
            isum[hit] += pi; icnt[hit]++;
          end
        end
      end else if (used >= SLOTS) begin
        ovf = 1;
      end else begin
        for (int a = 0; a < 3; a++) begin
          key[used][a] = k[a]; sum[used][a] = p[a]; first[used][a] = p[a];
        end
        cnt[used] = 1;
        isum[used] = ph ? pi : 0; icnt[used] = ph ? 1 : 0;
        first_int[used] = ph ? pi : 0; first_has[used] = ph;
        used++;
      end
      if (!pl) return;
      for (int s = 0; s < used; s++) begin
        c = cnt[s];
        if (avg)
          push(sum[s][0] / c, sum[s][1] / c, sum[s][2] / c,
               icnt[s] ? isum[s] / icnt[s] : 0, icnt[s] != 0,
               ovf ? ST_OVF : ST_OK, s + 1 == used);
        else
          push(first[s][0], first[s][1], first[s][2], first_int[s], first_has[s],
               ovf ? ST_OVF : ST_OK, s + 1 == used);
      end
      used = 0; ovf = 0;
    endfunction

    function void check_result(vox_out_t got);
      vox_out_t e;
      seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h", $time, got.x, got.y, got.z);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.x !== got.x || e.y !== got.y || e.z !== got.z || e.inten !== got.inten ||
          e.has !== got.has || e.st !== got.st || e.last !== got.last) begin
        $display("%0t: mismatch expected x=%h y=%h z=%h i=%h h=%b st=%0d l=%b",
                 $time, e.x, e.y, e.z, e.inten, e.has, e.st, e.last);
        $display("%0t:          actual   x=%h y=%h z=%h i=%h h=%b st=%0d l=%b",
                 $time, got.x, got.y, got.z, got.inten, got.has, got.st, got.last);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              s_axis_tvalid = 0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic              s_axis_tlast = 0;
  logic [0:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic              m_axis_tlast;
  logic [1:0]        m_axis_tuser;
  logic              cfg_we_i = 0;
  logic [0:0]        cfg_idx_i = '0;
  logic [VSIZE_W-1:0] cfg_data_i = '0;

  voxel_scoreboard sb = new();
  bit  calm;
  bit  hold_sink;
  int  idle_cycles;
  int  points_sent;

  always #4 clk_i = ~clk_i;

  voxel_grid_downsample_unit uut (.*);

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sb.note_point(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[63:32],
                    s_axis_tdata[95:64], s_axis_tdata[111:96], s_axis_tdata[112],
                    s_axis_tlast);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      vox_out_t r;
      r.x = m_axis_tdata[31:0]; r.y = m_axis_tdata[63:32]; r.z = m_axis_tdata[95:64];
      r.inten = m_axis_tdata[111:96]; r.has = m_axis_tdata[112];
      r.st = m_axis_tuser; r.last = m_axis_tlast;
      sb.check_result(r);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (idle_cycles > 200000) begin
      $display("tb_voxel_grid_downsample_unit: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !hold_sink && (calm || $urandom_range(99) >= 20);
  end

  task automatic write_reg(logic [0:0] idx, logic [VSIZE_W-1:0] val);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 0;
    if (idx == REG_VOXEL_SIZE) sb.vsize = val;
    else sb.avg = val[0];
    @(posedge clk_i);
  endtask

  task automatic send_point(logic f, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [15:0] i, logic h, logic l);
    int gap = 0;
    while (!calm && $urandom_range(99) < 20) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {7'd0, h, i, z, y, x};
    s_axis_tlast  <= l;
    s_axis_tuser  <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    points_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic logic [31:0] near_coord(int unsigned span);
    return $urandom_range(2 * span) - span;
  endfunction

  task automatic random_cloud(int n, int unsigned span, bit spicy);
    logic [31:0] x, y, z;
    for (int k = 0; k < n; k++) begin
      if (spicy && $urandom_range(9) == 0) begin
        x = $urandom(); y = $urandom(); z = $urandom();
      end else begin
        x = near_coord(span); y = near_coord(span); z = near_coord(span);
      end
      send_point(($urandom_range(19) == 0) ? ~FUNC_ADD : FUNC_ADD, x, y, z,
                 16'($urandom()), 1'($urandom_range(1)), 0);
    end
    send_point(FUNC_ADD, near_coord(span), near_coord(span), near_coord(span),
               16'($urandom()), 1'($urandom_range(1)), 1);
  endtask

  initial begin
    calm = 0;
    hold_sink = 0;
    idle_cycles = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, selector, shared voxel, negative floor, first-point mode, zero voxel size
    send_point(FUNC_ADD, 32'h7fffffff, 32'h80000000, 32'h0, 16'hffff, 1, 0);
    send_point(FUNC_ADD, 32'h7fff0000, 32'h80000001, 32'h0000ffff, 16'h0001, 1, 0);
    send_point(FUNC_ADD, 32'hffffffff, 32'h00000000, 32'hffff0000, 16'h1234, 0, 0);
    send_point(FUNC_ADD, 32'hffff0001, 32'hffffffff, 32'hfffe0000, 16'h0, 1, 0);
    send_point(~FUNC_ADD, 32'h1, 32'h2, 32'h3, 16'h4, 1, 1);
    send_point(FUNC_ADD, 32'h00010000, 32'h00018000, 32'h0001ffff, 16'hffff, 0, 1);
    settle();
    write_reg(REG_USE_AVG, 0);
    send_point(FUNC_ADD, 32'h00020000, 32'h0, 32'h0, 16'habcd, 1, 0);
    send_point(FUNC_ADD, 32'h00028000, 32'h0, 32'h0, 16'h1111, 1, 0);
    send_point(FUNC_ADD, 32'h80000000, 32'h7fffffff, 32'h0, 16'h0, 0, 1);
    settle();
    write_reg(REG_VOXEL_SIZE, 0);
    send_point(FUNC_ADD, 32'h5, 32'h6, 32'h7, 16'h8, 1, 0);
    send_point(FUNC_ADD, 32'h5, 32'h6, 32'h7, 16'h8, 1, 1);
    settle();
    write_reg(REG_VOXEL_SIZE, 31'h7fffffff);
    write_reg(REG_USE_AVG, 1);
    send_point(FUNC_ADD, 32'h7fffffff, 32'h7ffffffe, 32'h80000000, 16'h8000, 1, 0);
    send_point(FUNC_ADD, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 1, 1);
    settle();

    // table overflow: 70 distinct voxels at size 1
    write_reg(REG_VOXEL_SIZE, 31'd1);
    calm = 1;
    for (int k = 0; k < 70; k++)
      send_point(FUNC_ADD, 32'(k), 32'h0, 32'h0, 16'(k), k[0], k == 69);
    settle();

    // back-pressure: sink held off while clouds keep coming
    write_reg(REG_VOXEL_SIZE, 31'd65536);
    calm = 0;
    fork
      begin
        hold_sink = 1;
        repeat (3000) @(posedge clk_i);
        hold_sink = 0;
      end
      begin
        random_cloud(6, 32'h00030000, 0);
        random_cloud(6, 32'h00030000, 0);
      end
    join
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_VOXEL_SIZE, 31'h00010000); write_reg(REG_USE_AVG, 1); end
        1: begin write_reg(REG_VOXEL_SIZE, 31'h00008000); write_reg(REG_USE_AVG, 0); end
        2: begin write_reg(REG_VOXEL_SIZE, 31'd3); write_reg(REG_USE_AVG, 1); end
        3: begin write_reg(REG_VOXEL_SIZE, VSIZE_W'($urandom_range(31'h7fffffff, 1))); end
        4: begin write_reg(REG_VOXEL_SIZE, 31'h7fffffff); write_reg(REG_USE_AVG, 0); end
        default: begin write_reg(REG_VOXEL_SIZE, 31'h00040000); write_reg(REG_USE_AVG, 1); end
      endcase
      calm = (ph == 2);
      for (int c = 0; c < 5; c++)
        random_cloud($urandom_range(14), (ph == 2) ? 8 : 32'h00080000, 1);
      settle();
    end

    $display("covered %0d input transactions and %0d result transactions,", points_sent,
             sb.seen);
    $display("including overflow, zero voxel size, both output modes and a long sink stall");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_voxel_grid_downsample_unit: PASS");
    else
      $display("tb_voxel_grid_downsample_unit: FAIL");
    $finish;
  end

endmodule
